@@ src/tps_pkg.sv @@
// ----------------------------------------------------------------------------
// Triangle pixel shader package
// Widths, register indexes and stage counts shared by the shader modules.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int MAX_DIM_DEFAULT = 4096;

   localparam int COORD_W  = 12;
   localparam int VERT_W   = 16;
   localparam int FRAME_W  = 13;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 32;

   localparam int DIFF_W = VERT_W + 1;   // vertex difference
   localparam int PROD_W = 34;           // edge partial product
   localparam int BOX_W  = 18;           // box compare
   localparam int W_W    = 37;           // biased edge weight
   localparam int AREA_W = 36;
   localparam int D_W    = 36;           // |area|
   localparam int MUL_W  = 46;           // weight times channel
   localparam int NUM_W  = 48;
   localparam int T_W    = 50;           // 2*num + d
   localparam int DD_W   = D_W + 1;      // 2*d
   localparam int Q_W    = 8;
   localparam int REM_W  = DD_W + Q_W;

   localparam int FRONT_STAGES = 4;
   localparam int DIV_STAGES   = Q_W + 1;
   localparam int N_STAGES     = FRONT_STAGES + DIV_STAGES;

   localparam logic [CSR_IDX_W-1:0] REG_VERTEX0 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VERTEX1 = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VERTEX2 = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR0  = 4'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR1  = 4'd4;
   localparam logic [CSR_IDX_W-1:0] REG_COLOR2  = 4'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_W = 4'd6;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_H = 4'd7;

endpackage

@@ src/tps_div.sv @@
// ----------------------------------------------------------------------------
// Channel divider
// Pipelined restoring divide of one channel, saturated to 0..255.
// ----------------------------------------------------------------------------
module tps_div (
   input  logic                            clock,
   input  logic [tps_pkg::DIV_STAGES-1:0]  en,
   input  logic signed [tps_pkg::T_W-1:0]  t,
   input  logic [tps_pkg::DD_W-1:0]        dd,
   output logic [tps_pkg::Q_W-1:0]         chan
);
   import tps_pkg::*;

   logic [REM_W-1:0] rem_ff [DIV_STAGES];
   logic [DD_W-1:0]  dd_ff  [DIV_STAGES];
   logic [Q_W-1:0]   q_ff   [DIV_STAGES];
   logic             neg_ff [DIV_STAGES];
   logic             big_ff [DIV_STAGES];

   logic             neg_in;
   logic             big_in;

   assign neg_in = t < 0;
   assign big_in = !neg_in && (t >= signed'(T_W'({dd, 8'b0})));

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= t[REM_W-1:0];
         dd_ff[0]  <= dd;
         q_ff[0]   <= '0;
         neg_ff[0] <= neg_in;
         big_ff[0] <= big_in;
      end
   end

   for (genvar k = 1; k < DIV_STAGES; k++) begin : g_step
      localparam int B = Q_W - k;
      logic [REM_W-1:0] sub_in;
      logic             take_in;

      assign sub_in  = REM_W'(dd_ff[k-1]) << B;
      assign take_in = rem_ff[k-1] >= sub_in;

      always_ff @(posedge clock) begin
         if (en[k]) begin
            rem_ff[k] <= take_in ? rem_ff[k-1] - sub_in : rem_ff[k-1];
            q_ff[k]   <= q_ff[k-1] | (Q_W'(take_in) << B);
            dd_ff[k]  <= dd_ff[k-1];
            neg_ff[k] <= neg_ff[k-1];
            big_ff[k] <= big_ff[k-1];
         end
      end
   end

   assign chan = neg_ff[DIV_STAGES-1] ? '0 :
                 big_ff[DIV_STAGES-1] ? '1 : q_ff[DIV_STAGES-1];

endmodule

@@ src/triangle_pixel_shader_unit.sv @@
// ----------------------------------------------------------------------------
// Triangle pixel shader unit
// Edge-function coverage test with top-left rule and ARGB interpolation.
// ----------------------------------------------------------------------------
// Usage:
//   csr channel writes the three vertices, three colors and frame size;
//   write only while no request is in flight. csr_ready is always high.
//   req channel takes one pixel coordinate per request; rsp channel returns
//   the coordinate, write_enable on tuser and the interpolated color.
// Throughput: one request per cycle, sustained while rsp_tready stays high.
// Pipeline from request to response: four stages of edge and product
//   arithmetic, then one range stage and eight restoring divide steps,
//   one quotient bit per stage, per color channel.
// Reset clears the configuration registers and all stage valid bits.
// A stalled rsp holds its response; each stage advances when it is empty or
//   the stage after it advances, so bubbles close up and requests stop
//   entering only when every stage holds a request.
// ----------------------------------------------------------------------------
module triangle_pixel_shader_unit #(
   parameter int MAX_DIM = tps_pkg::MAX_DIM_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tps_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tps_pkg::CSR_DAT_W-1:0]    csr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [23:0]                      req_tdata,  // pixel_x, pixel_y
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [55:0]                      rsp_tdata,  // out_x, out_y, pixel_color
   output logic                             rsp_tuser   // write_enable
);
   import tps_pkg::*;

   localparam int N = N_STAGES;

   logic [31:0]        vertex_ff [3];
   logic [31:0]        color_ff  [3];
   logic [FRAME_W-1:0] fw_ff;
   logic [FRAME_W-1:0] fh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            vertex_ff[i] <= '0;
            color_ff[i]  <= '0;
         end
         fw_ff <= '0;
         fh_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_VERTEX0: vertex_ff[0] <= csr_data;
            REG_VERTEX1: vertex_ff[1] <= csr_data;
            REG_VERTEX2: vertex_ff[2] <= csr_data;
            REG_COLOR0:  color_ff[0]  <= csr_data;
            REG_COLOR1:  color_ff[1]  <= csr_data;
            REG_COLOR2:  color_ff[2]  <= csr_data;
            REG_FRAME_W: fw_ff        <= csr_data[FRAME_W-1:0];
            REG_FRAME_H: fh_ff        <= csr_data[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // stage valid and advance
   logic [N-1:0] vld_ff;
   logic [N-1:0] en;

   always_comb begin
      en[N-1] = !vld_ff[N-1] || rsp_tready;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (en[k]) begin
               vld_ff[k] <= (k == 0) ? req_tvalid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   assign req_tready = en[0];

   // coordinate and coverage travel down every stage
   logic [COORD_W-1:0] px_ff [N];
   logic [COORD_W-1:0] py_ff [N];
   logic               we_ff [N];
   logic               box_in;
   logic               we1_in;

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (en[k]) begin
            if (k == 0) begin
               px_ff[0] <= req_tdata[11:0];
               py_ff[0] <= req_tdata[23:12];
               we_ff[0] <= box_in;
            end else begin
               px_ff[k] <= px_ff[k-1];
               py_ff[k] <= py_ff[k-1];
               we_ff[k] <= (k == 1) ? we1_in : we_ff[k-1];
            end
         end
      end
   end

   // stage 0: vertex geometry, edge partial products, box test
   logic signed [VERT_W-1:0] vx [3];
   logic signed [VERT_W-1:0] vy [3];
   logic signed [COORD_W:0]  px_s;
   logic signed [COORD_W:0]  py_s;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vx[i] = signed'(vertex_ff[i][15:0]);
         vy[i] = signed'(vertex_ff[i][31:16]);
      end
   end

   assign px_s = signed'({1'b0, req_tdata[11:0]});
   assign py_s = signed'({1'b0, req_tdata[23:12]});

   logic signed [PROD_W-1:0] apy_ff [3];
   logic signed [PROD_W-1:0] bpx_ff [3];
   logic signed [PROD_W-1:0] aoy_ff [3];
   logic signed [PROD_W-1:0] box_ff [3];
   logic                     bias_ff [3];
   logic signed [PROD_W-1:0] q1_ff;
   logic signed [PROD_W-1:0] q2_ff;

   for (genvar e = 0; e < 3; e++) begin : g_edge
      localparam int O = (e + 1) % 3;
      localparam int A = (e + 2) % 3;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;

      assign dx = DIFF_W'(vx[A]) - DIFF_W'(vx[O]);
      assign dy = DIFF_W'(vy[A]) - DIFF_W'(vy[O]);

      always_ff @(posedge clock) begin
         if (en[0]) begin
            apy_ff[e]  <= PROD_W'(dx * py_s);
            bpx_ff[e]  <= PROD_W'(dy * px_s);
            aoy_ff[e]  <= PROD_W'(dx * vy[O]);
            box_ff[e]  <= PROD_W'(dy * vx[O]);
            bias_ff[e] <= !((dy > 0) || (dy == 0 && dx < 0));
         end
      end
   end

   logic signed [DIFF_W-1:0] ax_10;
   logic signed [DIFF_W-1:0] ay_20;
   logic signed [DIFF_W-1:0] ay_10;
   logic signed [DIFF_W-1:0] ax_20;

   assign ax_10 = DIFF_W'(vx[1]) - DIFF_W'(vx[0]);
   assign ay_20 = DIFF_W'(vy[2]) - DIFF_W'(vy[0]);
   assign ay_10 = DIFF_W'(vy[1]) - DIFF_W'(vy[0]);
   assign ax_20 = DIFF_W'(vx[2]) - DIFF_W'(vx[0]);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         q1_ff <= PROD_W'(ax_10 * ay_20);
         q2_ff <= PROD_W'(ay_10 * ax_20);
      end
   end

   logic signed [BOX_W-1:0] minx;
   logic signed [BOX_W-1:0] miny;
   logic signed [BOX_W-1:0] maxx;
   logic signed [BOX_W-1:0] maxy;
   logic signed [BOX_W-1:0] fw_c;
   logic signed [BOX_W-1:0] fh_c;

   always_comb begin
      minx = BOX_W'(vx[0]);
      miny = BOX_W'(vy[0]);
      maxx = BOX_W'(vx[0]);
      maxy = BOX_W'(vy[0]);
      for (int i = 1; i < 3; i++) begin
         if (BOX_W'(vx[i]) < minx) minx = BOX_W'(vx[i]);
         if (BOX_W'(vy[i]) < miny) miny = BOX_W'(vy[i]);
         if (BOX_W'(vx[i]) > maxx) maxx = BOX_W'(vx[i]);
         if (BOX_W'(vy[i]) > maxy) maxy = BOX_W'(vy[i]);
      end
      fw_c = signed'(BOX_W'(fw_ff));
      fh_c = signed'(BOX_W'(fh_ff));
      if (fw_c > signed'(BOX_W'(MAX_DIM))) fw_c = signed'(BOX_W'(MAX_DIM));
      if (fh_c > signed'(BOX_W'(MAX_DIM))) fh_c = signed'(BOX_W'(MAX_DIM));
      if (minx < 0) minx = '0;
      if (miny < 0) miny = '0;
      if (maxx > fw_c) maxx = fw_c;
      if (maxy > fh_c) maxy = fh_c;
      box_in = (BOX_W'(px_s) >= minx) && (BOX_W'(px_s) < maxx) &&
               (BOX_W'(py_s) >= miny) && (BOX_W'(py_s) < maxy);
   end

   // stage 1: biased weights and area
   logic signed [W_W-1:0]    w_in [3];
   logic signed [W_W-1:0]    w_ff [3];
   logic signed [AREA_W-1:0] area_in;
   logic signed [AREA_W-1:0] area_ff;

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         w_in[e] = W_W'(apy_ff[e]) - W_W'(bpx_ff[e]) - W_W'(aoy_ff[e]) +
                   W_W'(box_ff[e]) + signed'(W_W'({1'b0, bias_ff[e]}));
      end
      area_in = AREA_W'(q1_ff) - AREA_W'(q2_ff);
      we1_in  = we_ff[0] && (area_in != 0) &&
                (w_in[0] <= 0) && (w_in[1] <= 0) && (w_in[2] <= 0);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         w_ff    <= w_in;
         area_ff <= area_in;
      end
   end

   // stage 2: weight times channel products
   logic signed [MUL_W-1:0] m_ff [4][3];
   logic                    aneg_ff;
   logic [D_W-1:0]          d_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         for (int c = 0; c < 4; c++) begin
            for (int e = 0; e < 3; e++) begin
               m_ff[c][e] <= MUL_W'(w_ff[e] *
                             signed'({1'b0, color_ff[e][8*c +: 8]}));
            end
         end
         aneg_ff <= area_ff < 0;
         d_ff    <= (area_ff < 0) ? D_W'(-area_ff) : D_W'(area_ff);
      end
   end

   // stage 3: numerator, sign fix, round bias
   logic signed [NUM_W-1:0] num_in [4];
   logic signed [T_W-1:0]   t_ff   [4];
   logic [DD_W-1:0]         dd_ff;

   always_comb begin
      for (int c = 0; c < 4; c++) begin
         num_in[c] = NUM_W'(m_ff[c][0]) + NUM_W'(m_ff[c][1]) + NUM_W'(m_ff[c][2]);
         if (aneg_ff) num_in[c] = -num_in[c];
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         for (int c = 0; c < 4; c++) begin
            t_ff[c] <= (T_W'(num_in[c]) <<< 1) + signed'(T_W'(d_ff));
         end
         dd_ff <= {d_ff, 1'b0};
      end
   end

   // stages 4 to 12: per-channel divide
   logic [Q_W-1:0] chan [4];

   for (genvar c = 0; c < 4; c++) begin : g_chan
      tps_div u_div (
         .clock (clock),
         .en    (en[N-1:FRONT_STAGES]),
         .t     (t_ff[c]),
         .dd    (dd_ff),
         .chan  (chan[c])
      );
   end

   assign rsp_tvalid = vld_ff[N-1];
   assign rsp_tuser  = we_ff[N-1];
   assign rsp_tdata  = {we_ff[N-1] ? {chan[3], chan[2], chan[1], chan[0]} : 32'd0,
                        py_ff[N-1], px_ff[N-1]};

endmodule

@@ src/tps_checker.sv @@
// ----------------------------------------------------------------------------
// Triangle pixel shader checker
// Port-level properties of the shader unit, bound to the top level.
// ----------------------------------------------------------------------------
module tps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        rsp_tuser
);

   // drop color on undrawn pixels
   a_undrawn_black: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[55:24] == 32'd0)
      else $error("undrawn pixel carries color");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser))
      else $error("stalled response changed");

   // accept while the output side is free
   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("request refused with free output");

endmodule

bind triangle_pixel_shader_unit tps_checker u_tps_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ bench/triangle_pixel_shader_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Triangle pixel shader unit testbench
// Drives pixel requests against several triangle and frame settings and
// checks coverage, pass-through coordinates and interpolated color of every
// response against a predictor built into the scoreboard.
// ----------------------------------------------------------------------------
module triangle_pixel_shader_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tps_pkg::*;

   typedef struct packed {
      logic [11:0] x;
      logic [11:0] y;
      logic        we;
      logic [31:0] color;
   } pixel_rsp_type;

   class shade_scoreboard;
      logic [31:0] vert [3];
      logic [31:0] col [3];
      logic [12:0] fw, fh;
      pixel_rsp_type pending [$];
      int          errors;
      int          checked;
      int          drawn;

      function new();
         foreach (vert[i]) begin
            vert[i] = 0;
            col[i] = 0;
         end
         fw = 0;
         fh = 0;
         errors = 0;
         checked = 0;
         drawn = 0;
      endfunction

      function void set_reg(logic [3:0] idx, logic [31:0] d);
         case (idx)
            REG_VERTEX0, REG_VERTEX1, REG_VERTEX2: vert[idx] = d;
            REG_COLOR0, REG_COLOR1, REG_COLOR2: col[idx - REG_COLOR0] = d;
            REG_FRAME_W: fw = d[12:0];
            REG_FRAME_H: fh = d[12:0];
            default: ;
         endcase
      endfunction

      function longint vx(int i);
         return longint'($signed(vert[i][15:0]));
      endfunction

      function longint vy(int i);
         return longint'($signed(vert[i][31:16]));
      endfunction

      function longint edge_fn(int o, int a, longint bx, longint by);
         return (vx(a) - vx(o)) * (by - vy(o)) - (vy(a) - vy(o)) * (bx - vx(o));
      endfunction

      function longint bias(int o, int n);
         longint dx, dy;
         dx = vx(n) - vx(o);
         dy = vy(n) - vy(o);
         return (dy > 0 || (dy == 0 && dx < 0)) ? 0 : 1;
      endfunction

      function void note_pixel(logic [11:0] px, logic [11:0] py);
         pixel_rsp_type r;
         longint x, y, cw, ch, lox, loy, hix, hiy, area, num, d, t, dd, q;
         longint w [3];
         x = px;
         y = py;
         cw = (fw > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : fw;
         ch = (fh > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : fh;
         lox = vx(0); hix = vx(0); loy = vy(0); hiy = vy(0);
         for (int i = 1; i < 3; i++) begin
            if (vx(i) < lox) lox = vx(i);
            if (vx(i) > hix) hix = vx(i);
            if (vy(i) < loy) loy = vy(i);
            if (vy(i) > hiy) hiy = vy(i);
         end
         if (lox < 0) lox = 0;
         if (loy < 0) loy = 0;
         if (hix > cw) hix = cw;
         if (hiy > ch) hiy = ch;
         area = edge_fn(0, 1, vx(2), vy(2));
         w[0] = edge_fn(1, 2, x, y) + bias(1, 2);
         w[1] = edge_fn(2, 0, x, y) + bias(2, 0);
         w[2] = edge_fn(0, 1, x, y) + bias(0, 1);
         r.x = px;
         r.y = py;
         r.color = 0;
         r.we = area != 0 && x >= lox && x < hix && y >= loy && y < hiy &&
                w[0] <= 0 && w[1] <= 0 && w[2] <= 0;
         if (r.we) begin
            for (int sh = 0; sh < 32; sh += 8) begin
               num = 0;
               for (int i = 0; i < 3; i++) num += w[i] * longint'((col[i] >> sh) & 8'hFF);
               if (area < 0) begin
                  num = -num;
                  d = -area;
               end else begin
                  d = area;
               end
               t = 2 * num + d;
               dd = 2 * d;
               q = t / dd;
               if (t % dd != 0 && t < 0) q -= 1;
               if (q < 0) q = 0;
               if (q > 255) q = 255;
               r.color[sh +: 8] = q[7:0];
            end
         end
         pending.push_back(r);
      endfunction

      task report(string what, longint got, longint want);
         $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, want);
         errors++;
      endtask

      task check_pixel(logic [55:0] data, logic we);
         pixel_rsp_type e;
         if (pending.size() == 0) begin
            report("unexpected response", data, 0);
            return;
         end
         e = pending.pop_front();
         checked++;
         if (e.we) drawn++;
         if (data[11:0] !== e.x) report("out_x", data[11:0], e.x);
         if (data[23:12] !== e.y) report("out_y", data[23:12], e.y);
         if (we !== e.we) report("write_enable", we, e.we);
         if (data[55:24] !== e.color) report("pixel_color", data[55:24], e.color);
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [3:0]  csr_index = 0;
   logic [31:0] csr_data = 0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [23:0] req_tdata = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        rsp_tuser;

   int send_idle = 0;
   int recv_idle = 0;
   int hold_cycles = 0;
   int sent = 0;
   shade_scoreboard sb = new();

   triangle_pixel_shader_unit uut (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_pixel(rsp_tdata, rsp_tuser);
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   task automatic write_reg(logic [3:0] idx, logic [31:0] d);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, d);
   endtask

   task automatic send_pixel(logic [11:0] px, logic [11:0] py);
      if ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {py, px};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_pixel(px, py);
      sent++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (N_STAGES + 4) @(posedge clock);
   endtask

   function automatic logic [31:0] pack_xy(int x, int y);
      return {y[15:0], x[15:0]};
   endfunction

   task automatic set_triangle(int x0, int y0, int x1, int y1, int x2, int y2,
                               logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                               int w, int h);
      write_reg(REG_VERTEX0, pack_xy(x0, y0));
      write_reg(REG_VERTEX1, pack_xy(x1, y1));
      write_reg(REG_VERTEX2, pack_xy(x2, y2));
      write_reg(REG_COLOR0, c0);
      write_reg(REG_COLOR1, c1);
      write_reg(REG_COLOR2, c2);
      write_reg(REG_FRAME_W, w);
      write_reg(REG_FRAME_H, h);
      csr_valid <= 0;
   endtask

   task automatic random_near(int n, int span);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) == 0) send_pixel($urandom, $urandom);
         else send_pixel($urandom_range(span), $urandom_range(span));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      send_pixel(0, 0);
      send_pixel(12'hFFF, 12'hFFF);
      drain();
      set_triangle(0, 0, 0, 20, 20, 0, 32'hFF0000FF, 32'h00FF00FF, 32'h0000FFFF, 64, 64);
      send_pixel(0, 0);
      send_pixel(5, 5);
      send_pixel(10, 10);
      send_pixel(19, 0);
      send_pixel(0, 19);
      send_pixel(20, 0);
      send_pixel(3, 12);
      send_pixel(12'hFFF, 0);
      send_pixel(0, 12'hFFF);
      send_pixel(12'hAAA, 12'h555);
      send_pixel(12'h555, 12'hAAA);
      drain();
      set_triangle(0, 0, 10, 10, 20, 20, 32'hFFFFFFFF, 0, 0, 64, 64);
      send_pixel(5, 5);
      send_pixel(10, 10);
      drain();
      set_triangle(-32768, -32768, 32767, -32768, -32768, 32767,
                   32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 8191, 8191);
      send_pixel(0, 0);
      send_pixel(4095, 4095);
      send_pixel(4095, 0);
      send_pixel(100, 3000);
      drain();

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 38 : (phase == 1) ? 54 : 0;
         recv_idle = (phase == 0) ? 54 : (phase == 1) ? 38 : 0;
         for (int t = 0; t < 4; t++) begin
            int sp;
            sp = (t == 3) ? 4095 : 63;
            set_triangle($urandom_range(sp + 8) - 4, $urandom_range(sp + 8) - 4,
                         $urandom_range(sp + 8) - 4, $urandom_range(sp + 8) - 4,
                         $urandom_range(sp + 8) - 4, $urandom_range(sp + 8) - 4,
                         $urandom, $urandom, $urandom, $urandom_range(8191),
                         (t == 0) ? 0 : $urandom_range(sp + 16));
            if (phase == 2 && t == 1) hold_cycles = 60;
            random_near(55, sp);
            drain();
         end
      end
      $display("Covered %0d pixel requests, %0d responses checked, %0d drawn.",
               sent, sb.checked, sb.drawn);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule

@@ triangle_pixel_shader_unit.f @@
src/tps_pkg.sv
src/tps_div.sv
src/triangle_pixel_shader_unit.sv
src/tps_checker.sv
bench/triangle_pixel_shader_unit_tb.sv
